[rtl/gor_pkg.sv]
// Shared types and constants for the Gram orthogonality residual block.
`default_nettype none

package gor_pkg;

  // Field widths fixed by the interface.
  localparam int ELEM_W  = 16;
  localparam int VALUE_W = 40;
  localparam int IDX_W   = 6;

  // Q.14 truncation shift for the norm components.
  localparam int FRAC_SHIFT = 14;
  localparam int TRUNC_W    = VALUE_W - FRAC_SHIFT;
  localparam int SQ_W       = 2 * TRUNC_W;

  // Sum of squares width; covers every supported matrix size and is even for the root.
  localparam int SUMSQ_W = 58;

  localparam logic signed [VALUE_W-1:0] ONE_Q28   = VALUE_W'(64'sd268435456);
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  // Largest root that still fits once shifted back up to Q12.28.
  localparam logic [SUMSQ_W-1:0] ROOT_MAX = SUMSQ_W'((64'd1 << (VALUE_W-1-FRAC_SHIFT)) - 64'd1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_MAC,
    S_DRAIN,
    S_EMIT,
    S_SQUARE,
    S_ACCUM,
    S_ROOT,
    S_NORM
  } gor_state_t;

endpackage

`default_nettype wire

[rtl/gor_ram.sv]
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module gor_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered reads.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[rtl/gram_orthogonality_residual.sv]
// Top level: matrix loader, shared multiply-accumulate sequencer and bit-serial square root.
// Loading takes one beat per cycle while in S_LOAD; the beat that completes the matrix
// starts the residual run. Each of the N(N+1)/2 row products runs on the single 16x16
// multiplier and the accumulator; the norm then takes SUMSQ_W/2 = 29 root steps.
// No new element is taken during a run. The output register lets the next matrix load while
// the norm beat waits. Synchronous reset clears the sequencer, load count and output valid.
`default_nettype none

module gram_orthogonality_residual #(
  parameter int MATRIX_DIM = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [gor_pkg::ELEM_W-1:0]   element_value,
  input  wire logic                                frame_start,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [gor_pkg::VALUE_W-1:0]  result_value,
  output logic             [gor_pkg::IDX_W-1:0]    component_index,
  output logic                                     is_norm,
  output logic                                     last_result
);

  import gor_pkg::*;

  localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
  localparam int ADDR_W     = $clog2(ELEM_COUNT);
  localparam int CNT_W      = $clog2(ELEM_COUNT + 1);
  localparam int ROW_W      = $clog2(MATRIX_DIM);

  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(ELEM_COUNT);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(MATRIX_DIM - 1);
  localparam logic [ROW_W-1:0]  ROW_PENULT = ROW_W'(MATRIX_DIM - 2);
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MATRIX_DIM);

  gor_state_t state, state_next;

  // Control decoded from the state.
  logic in_fire;
  logic issue;
  logic out_free;
  logic emit_term;
  logic emit_norm;
  logic last_pair;

  // Loader.
  logic [CNT_W-1:0]  load_count;
  logic [CNT_W-1:0]  load_count_next;
  logic [ADDR_W-1:0] waddr;

  // Pair sequencer.
  logic              diag;
  logic [ROW_W-1:0]  row_a;
  logic [ROW_W-1:0]  row_b;
  logic [ADDR_W-1:0] base_a;
  logic [ADDR_W-1:0] base_b;
  logic [ROW_W-1:0]  col;
  logic [IDX_W-1:0]  comp_idx;

  // Datapath.
  logic [ELEM_W-1:0]         rdata_a;
  logic [ELEM_W-1:0]         rdata_b;
  logic signed [ELEM_W-1:0]  elem_a;
  logic signed [ELEM_W-1:0]  elem_b;
  logic                      rd_pend;
  logic                      prod_pend;
  logic signed [2*ELEM_W-1:0] prod;
  logic signed [VALUE_W-1:0] acc;
  logic signed [VALUE_W-1:0] term_val;
  logic signed [TRUNC_W-1:0] trunc;
  logic signed [SQ_W-1:0]    sq;
  logic [SUMSQ_W-1:0]        sumsq;
  logic [SUMSQ_W-1:0]        sumsq_next;

  // Square root.
  logic [SUMSQ_W-1:0]        rem;
  logic [SUMSQ_W-1:0]        root;
  logic [SUMSQ_W-1:0]        root_bit;
  logic [SUMSQ_W-1:0]        trial;
  logic                      trial_ok;
  logic signed [VALUE_W-1:0] norm_val;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_fire && load_count_next == CNT_FULL) begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        if (col == ROW_LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_pend && !prod_pend) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: state_next = S_ACCUM;
      S_ACCUM: begin
        state_next = last_pair ? S_ROOT : S_MAC;
      end
      S_ROOT: begin
        if (root_bit[0]) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (out_free) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = (state == S_LOAD);
    in_fire   = in_ready && in_valid;
    issue     = (state == S_MAC);
    out_free  = !out_valid || out_ready;
    emit_term = (state == S_EMIT) && out_free;
    emit_norm = (state == S_NORM) && out_free;
    last_pair = !diag && (row_a == ROW_PENULT) && (row_b == ROW_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Element loader; a frame start or a completed matrix restarts at element zero.
  assign waddr           = frame_start ? '0 : load_count[ADDR_W-1:0];
  assign load_count_next = CNT_W'(waddr) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (in_fire) begin
      load_count <= (load_count_next == CNT_FULL) ? '0 : load_count_next;
    end
  end

  gor_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (ELEM_COUNT)
  ) u_store (
    .clk     (clk),
    .we      (in_fire),
    .waddr   (waddr),
    .wdata   (element_value),
    .raddr_a (base_a + ADDR_W'(col)),
    .raddr_b (base_b + ADDR_W'(col)),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Row pair walk: diagonal pairs first, then upper pairs in row order.
  always_ff @(posedge clk) begin
    if (rst) begin
      diag     <= 1'b1;
      row_a    <= '0;
      row_b    <= '0;
      base_a   <= '0;
      base_b   <= '0;
      col      <= '0;
      comp_idx <= '0;
    end else if (in_fire) begin
      diag     <= 1'b1;
      row_a    <= '0;
      row_b    <= '0;
      base_a   <= '0;
      base_b   <= '0;
      col      <= '0;
      comp_idx <= '0;
    end else begin
      if (issue) begin
        col <= (col == ROW_LAST) ? '0 : col + ROW_W'(1);
      end
      if (emit_term) begin
        comp_idx <= comp_idx + IDX_W'(1);
      end
      if (state == S_ACCUM && !last_pair) begin
        if (diag) begin
          if (row_a == ROW_LAST) begin
            diag   <= 1'b0;
            row_a  <= '0;
            row_b  <= ROW_W'(1);
            base_a <= '0;
            base_b <= ROW_STEP;
          end else begin
            row_a  <= row_a + ROW_W'(1);
            row_b  <= row_b + ROW_W'(1);
            base_a <= base_a + ROW_STEP;
            base_b <= base_b + ROW_STEP;
          end
        end else if (row_b == ROW_LAST) begin
          row_a  <= row_a + ROW_W'(1);
          row_b  <= row_a + ROW_W'(2);
          base_a <= base_a + ROW_STEP;
          base_b <= base_a + ROW_STEP + ROW_STEP;
        end else begin
          row_b  <= row_b + ROW_W'(1);
          base_b <= base_b + ROW_STEP;
        end
      end
    end
  end

  // Shared multiplier and accumulator pipeline.
  assign elem_a = signed'(rdata_a);
  assign elem_b = signed'(rdata_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      prod_pend <= 1'b0;
    end else begin
      rd_pend   <= issue;
      prod_pend <= rd_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      prod <= elem_a * elem_b;
    end
    if (in_fire || state == S_ACCUM) begin
      acc <= '0;
    end else if (prod_pend) begin
      acc <= acc + VALUE_W'(prod);
    end
  end

  // Diagonal terms drop the identity and halve, rounding toward minus infinity.
  always_comb begin
    if (diag) begin
      term_val = (acc - ONE_Q28) >>> 1;
    end else begin
      term_val = acc;
    end
  end

  // Squares of the Q.14 components are summed for the norm.
  assign sumsq_next = sumsq + SUMSQ_W'($unsigned(sq));

  always_ff @(posedge clk) begin
    if (emit_term) begin
      trunc <= TRUNC_W'(term_val >>> FRAC_SHIFT);
    end
    if (state == S_SQUARE) begin
      sq <= trunc * trunc;
    end
    if (in_fire) begin
      sumsq <= '0;
    end else if (state == S_ACCUM) begin
      sumsq <= sumsq_next;
    end
  end

  // Bit-serial floor square root, two radicand bits per step.
  assign trial    = root + root_bit;
  assign trial_ok = (rem >= trial);

  always_ff @(posedge clk) begin
    if (state == S_ACCUM) begin
      rem      <= sumsq_next;
      root     <= '0;
      root_bit <= SUMSQ_W'(1) << (SUMSQ_W - 2);
    end else if (state == S_ROOT) begin
      if (trial_ok) begin
        rem  <= rem - trial;
        root <= (root >> 1) + root_bit;
      end else begin
        root <= root >> 1;
      end
      root_bit <= root_bit >> 2;
    end
  end

  // The norm saturates at the largest Q12.28 value.
  always_comb begin
    if (root > ROOT_MAX) begin
      norm_val = VALUE_MAX;
    end else begin
      norm_val = VALUE_W'(root) <<< FRAC_SHIFT;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_term || emit_norm) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_term) begin
      result_value    <= term_val;
      component_index <= comp_idx;
      is_norm         <= 1'b0;
      last_result     <= 1'b0;
    end else if (emit_norm) begin
      result_value    <= norm_val;
      component_index <= '0;
      is_norm         <= 1'b1;
      last_result     <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/gor_checker.sv]
// Port-level checker for the Gram orthogonality residual block, bound to the top level.
`default_nettype none

module gor_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [gor_pkg::VALUE_W-1:0] result_value,
  input wire logic        [gor_pkg::IDX_W-1:0]   component_index,
  input wire logic                               is_norm,
  input wire logic                               last_result
);

  import gor_pkg::*;

  // Reset leaves no beat pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Only the norm beat closes a run.
  a_last_is_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_norm == last_result))
    else $error("last flag and norm flag disagree");

  // The norm beat carries index zero.
  a_norm_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_norm) |-> (component_index == '0))
    else $error("norm beat with nonzero index");

  // A stalled beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_value)
                                   && $stable(component_index) && $stable(is_norm)))
    else $error("stalled output beat changed");

endmodule

bind gram_orthogonality_residual gor_checker u_gor_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .result_value    (result_value),
  .component_index (component_index),
  .is_norm         (is_norm),
  .last_result     (last_result)
);

`default_nettype wire

[verif/gram_orthogonality_residual_tb.sv]
// Self-checking testbench for the Gram orthogonality residual block.
`timescale 1ns / 1ps

module tb;
  import gor_pkg::*;

  localparam int DIM        = 4;
  localparam int ELEM_COUNT = DIM * DIM;
  localparam int ITEM_COUNT = 330;
  localparam int TAIL_WAIT  = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT   = 23;
  localparam int PRINT_CAP  = 30;

  // One residual beat as it leaves the block.
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          index;
    logic                      norm;
    logic                      last;
  } residual_beat_t;

  // Tracks the loaded matrix, predicts the residual beats and checks them in order.
  class residual_scoreboard;
    logic signed [ELEM_W-1:0] store [ELEM_COUNT];
    int unsigned fill;
    residual_beat_t awaited [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned frames;

    function new();
      fill = 0;
      mismatches = 0;
      checked = 0;
      frames = 0;
      foreach (store[k]) store[k] = '0;
    endfunction

    task report(string what);
      if (mismatches < PRINT_CAP) $display("[%0t] residual error: %s", $realtime, what);
      mismatches++;
    endtask

    // Exact dot product of two stored rows, Q12.28.
    function longint row_dot(int a, int b);
      longint acc;
      acc = 0;
      for (int c = 0; c < DIM; c++)
        acc += longint'(store[a*DIM+c]) * longint'(store[b*DIM+c]);
      return acc;
    endfunction

    // Floor integer square root, one result bit per step.
    function longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe >>= 2;
      while (probe != 0) begin
        if (x >= root + probe) begin
          x -= root + probe;
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    function void push_beat(longint value, int index, logic norm);
      residual_beat_t b;
      b.value = VALUE_W'(value);
      b.index = IDX_W'(index);
      b.norm  = norm;
      b.last  = norm;
      awaited.push_back(b);
    endfunction

    // An accepted element; the one that completes a matrix queues the whole residual set.
    function void note_element(logic signed [ELEM_W-1:0] elem, logic fs);
      longint d;
      longint t;
      longint unsigned sumsq;
      longint unsigned root;
      int idx;
      if (fs || fill >= ELEM_COUNT) fill = 0;
      store[fill] = elem;
      fill++;
      if (fill < ELEM_COUNT) return;
      fill = 0;
      frames++;
      sumsq = 0;
      idx = 0;
      for (int i = 0; i < DIM; i++) begin
        d = (row_dot(i, i) - (longint'(1) << 28)) >>> 1;
        t = d >>> FRAC_SHIFT;
        sumsq += longint'(t * t);
        push_beat(d, idx, 1'b0);
        idx++;
      end
      for (int i = 0; i < DIM; i++) begin
        for (int j = i + 1; j < DIM; j++) begin
          d = row_dot(i, j);
          t = d >>> FRAC_SHIFT;
          sumsq += longint'(t * t);
          push_beat(d, idx, 1'b0);
          idx++;
        end
      end
      root = floor_sqrt(sumsq);
      if (root > ((longint'(1) << (VALUE_W - 1 - FRAC_SHIFT)) - 1))
        push_beat(longint'(VALUE_MAX), 0, 1'b1);
      else
        push_beat(longint'(root << FRAC_SHIFT), 0, 1'b1);
    endfunction

    // Compares one output beat with the oldest prediction, field by field.
    task check_beat(logic signed [VALUE_W-1:0] value, logic [IDX_W-1:0] index,
                    logic norm, logic last);
      residual_beat_t exp_beat;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected beat value=%0d index=%0d norm=%b last=%b",
                         value, index, norm, last));
        return;
      end
      exp_beat = awaited.pop_front();
      checked++;
      if (value !== exp_beat.value)
        report($sformatf("value %0d, expected %0d (index %0d)", value, exp_beat.value,
                         exp_beat.index));
      if (index !== exp_beat.index)
        report($sformatf("component_index %0d, expected %0d", index, exp_beat.index));
      if (norm !== exp_beat.norm)
        report($sformatf("is_norm %b, expected %b", norm, exp_beat.norm));
      if (last !== exp_beat.last)
        report($sformatf("last_result %b, expected %b", last, exp_beat.last));
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ELEM_W-1:0] element_value = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VALUE_W-1:0] result_value;
  logic [IDX_W-1:0] component_index;
  logic is_norm;
  logic last_result;

  residual_scoreboard sb = new();
  bit steady = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;

  gram_orthogonality_residual #(.MATRIX_DIM(DIM)) i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .element_value   (element_value),
    .frame_start     (frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_value    (result_value),
    .component_index (component_index),
    .is_norm         (is_norm),
    .last_result     (last_result)
  );

  always #10 clk = ~clk;

  // Run limit in case the block stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still awaited", cycle_count, sb.pending());
      $display("gram_orthogonality_residual: mismatch");
      $finish;
    end
  end

  // Output side: check each accepted beat, then stall at random for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_beat(result_value, component_index, is_norm, last_result);
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Sends one element beat, with an occasional gap in front of it.
  task send_element(logic signed [ELEM_W-1:0] elem, logic fs);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= elem;
    frame_start   <= fs;
    do @(posedge clk); while (!in_ready);
    sb.note_element(elem, fs);
    beats_sent++;
  endtask

  // Random element whose spread depends on the matrix flavor.
  function logic signed [ELEM_W-1:0] pick_element(int flavor, int pos);
    logic signed [ELEM_W-1:0] e;
    case (flavor)
      0: e = ELEM_W'($urandom);
      1: e = ELEM_W'(((pos / DIM) == (pos % DIM) ? 16384 : 0) + $urandom_range(0, 256) - 128);
      2: begin
        case ($urandom_range(0, 3))
          0: e = 16'sh8000;
          1: e = 16'sh7fff;
          2: e = 16'sh0000;
          default: e = 16'shffff;
        endcase
      end
      default: e = ELEM_W'($urandom_range(0, 4095) - 2048);
    endcase
    return e;
  endfunction

  // Stimulus: directed extremes, then mostly well-formed random matrices with some broken ones.
  initial begin
    int flavor;
    int len;
    logic fs;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A full matrix of field extremes, opened by a frame start.
    for (int k = 0; k < ELEM_COUNT; k++) begin
      case (k % 4)
        0: send_element(16'sh8000, k == 0);
        1: send_element(16'sh7fff, 1'b0);
        2: send_element(16'sh0000, 1'b0);
        default: send_element(16'shffff, 1'b0);
      endcase
    end
    // Elements after a complete matrix start a new one without a frame start;
    // this partial one is discarded only if the next matrix opens with a frame start.
    send_element(16'sh4000, 1'b0);
    send_element(16'shc000, 1'b0);
    send_element(16'sh0001, 1'b0);
    send_element(16'sh7fff, 1'b0);

    while (beats_sent < ITEM_COUNT) begin
      steady = (beats_sent >= 150 && beats_sent < 220);
      flavor = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 15) begin
        len = $urandom_range(1, ELEM_COUNT - 1);
        fs = $urandom_range(0, 1);
      end else begin
        len = ELEM_COUNT;
        fs = ($urandom_range(0, 99) < 75);
      end
      for (int k = 0; k < len; k++)
        send_element(pick_element(flavor, k), (k == 0) ? fs : 1'b0);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray beat.
    while (sb.pending() > 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d element beats; %0d complete matrices produced %0d checked residual beats.",
             beats_sent, sb.frames, sb.checked);
    $display("Errors found: %0d.", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("gram_orthogonality_residual: match");
    else
      $display("gram_orthogonality_residual: mismatch");
    $finish;
  end

endmodule
